### rtl/dda_pkg.sv
package dda_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned FRAC_BITS  = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic tick;
    logic div_step;
    logic div_first;
    logic div_last;
  } dda_cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic last_step;
  } dda_sts_t;

endpackage

### rtl/dda_in_if.sv
interface dda_in_if #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, output ready);
endinterface

### rtl/dda_out_if.sv
interface dda_out_if #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_point;

  modport source (output valid, pixel_x, pixel_y, last_point, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_point, output ready);
endinterface

### rtl/dda_ctrl.sv
module dda_ctrl #(
  parameter int unsigned FRAC_BITS = dda_pkg::FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              opcode_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dda_pkg::dda_sts_t sts_i,
  output dda_pkg::dda_cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(FRAC_BITS + 1);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            active_q;
  logic            out_valid_q;
  logic            accept;

  // new item only while not dividing and the output register can take a result
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept && (opcode_i == dda_pkg::OP_LOAD);
    cmd_o.tick      = accept && (opcode_i == dda_pkg::OP_STEP) && active_q;
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.div_first = (state_q == S_DIV) && (cnt_q == '0);
    cmd_o.div_last  = (state_q == S_DIV) && (cnt_q == CntW'(FRAC_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load || cmd_o.tick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.load) begin
            cnt_q <= '0;
            if (sts_i.steps_zero) begin
              active_q <= 1'b0;
            end else begin
              active_q <= 1'b1;
              state_q  <= S_DIV;
            end
          end else if (cmd_o.tick && sts_i.last_step) begin
            active_q <= 1'b0;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cmd_o.div_last) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/dda_dp.sv
module dda_dp #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS
) (
  input  logic                  clk_i,
  input  dda_pkg::dda_cmd_t     cmd_i,
  output dda_pkg::dda_sts_t     sts_o,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_point_o
);

  localparam int unsigned AccW = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned IncW = FRAC_BITS + 2;
  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned RemW = COORD_BITS + 1;
  localparam logic [AccW-1:0] Half = AccW'(1) << (FRAC_BITS - 1);

  logic [COORD_BITS-1:0] adx, ady, steps;
  logic                  x_neg, y_neg;

  logic [AccW-1:0]       acc_x_q, acc_y_q, acc_x_d, acc_y_d, rnd_x, rnd_y;
  logic [IncW-1:0]       inc_x_q, inc_y_q;
  logic [QW-1:0]         q_x_q, q_y_q, q_x_d, q_y_d;
  logic [RemW-1:0]       rem_x_q, rem_y_q, rem_x_d, rem_y_d, shx, shy, dvs;
  logic                  ge_x, ge_y;
  logic                  neg_x_q, neg_y_q;
  logic [COORD_BITS-1:0] steps_q, left_q;

  assign x_neg = (x_end_i < x_start_i);
  assign y_neg = (y_end_i < y_start_i);
  assign adx   = x_neg ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
  assign ady   = y_neg ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
  assign steps = (adx > ady) ? adx : ady;

  assign sts_o.steps_zero = (steps == '0);
  assign sts_o.last_step  = (left_q == COORD_BITS'(1));

  // restoring divide, one quotient bit per cycle; the first bit is the integer bit
  assign dvs     = {1'b0, steps_q};
  assign shx     = cmd_i.div_first ? rem_x_q : {rem_x_q[RemW-2:0], 1'b0};
  assign shy     = cmd_i.div_first ? rem_y_q : {rem_y_q[RemW-2:0], 1'b0};
  assign ge_x    = (shx >= dvs);
  assign ge_y    = (shy >= dvs);
  assign rem_x_d = ge_x ? (shx - dvs) : shx;
  assign rem_y_d = ge_y ? (shy - dvs) : shy;
  assign q_x_d   = {q_x_q[QW-2:0], ge_x};
  assign q_y_d   = {q_y_q[QW-2:0], ge_y};

  assign acc_x_d = acc_x_q + {{(AccW-IncW){inc_x_q[IncW-1]}}, inc_x_q};
  assign acc_y_d = acc_y_q + {{(AccW-IncW){inc_y_q[IncW-1]}}, inc_y_q};
  assign rnd_x   = acc_x_d + Half;
  assign rnd_y   = acc_y_d + Half;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_x_q      <= {1'b0, x_start_i, {FRAC_BITS{1'b0}}};
      acc_y_q      <= {1'b0, y_start_i, {FRAC_BITS{1'b0}}};
      rem_x_q      <= RemW'(adx);
      rem_y_q      <= RemW'(ady);
      q_x_q        <= '0;
      q_y_q        <= '0;
      neg_x_q      <= x_neg;
      neg_y_q      <= y_neg;
      steps_q      <= steps;
      left_q       <= steps;
      pixel_x_o    <= x_start_i;
      pixel_y_o    <= y_start_i;
      last_point_o <= (steps == '0);
    end else if (cmd_i.tick) begin
      acc_x_q      <= acc_x_d;
      acc_y_q      <= acc_y_d;
      left_q       <= left_q - COORD_BITS'(1);
      pixel_x_o    <= rnd_x[FRAC_BITS +: COORD_BITS];
      pixel_y_o    <= rnd_y[FRAC_BITS +: COORD_BITS];
      last_point_o <= sts_o.last_step;
    end

    if (cmd_i.div_step) begin
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      q_x_q   <= q_x_d;
      q_y_q   <= q_y_d;
    end

    if (cmd_i.div_last) begin
      inc_x_q <= neg_x_q ? (IncW'(0) - {1'b0, q_x_d}) : {1'b0, q_x_d};
      inc_y_q <= neg_y_q ? (IncW'(0) - {1'b0, q_y_d}) : {1'b0, q_y_d};
    end
  end

endmodule

### rtl/dda_line_rasterizer_core.sv
// dda line rasterizer: a load item puts the start point in the output register, valid the cycle
// after; a line of non-zero length runs a bit-serial division, during which no item is taken.
// step items are then taken one per cycle unless the output stalls, each point valid the cycle
// after; a step with no line active gives nothing. an output register decouples the sides.
// asynchronous active-low reset idles the controller and empties the output; no clearing pass.
module dda_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS
) (
  input logic        clk_i,
  input logic        rst_ni,
  dda_in_if.sink     in_i,
  dda_out_if.source  out_o
);

  dda_pkg::dda_cmd_t cmd;
  dda_pkg::dda_sts_t sts;

  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dda_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .x_start_i    (in_i.x_start),
    .y_start_i    (in_i.y_start),
    .x_end_i      (in_i.x_end),
    .y_end_i      (in_i.y_end),
    .pixel_x_o    (out_o.pixel_x),
    .pixel_y_o    (out_o.pixel_y),
    .last_point_o (out_o.last_point)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_BITS = dda_pkg::COORD_BITS;
  localparam int FRAC_BITS  = dda_pkg::FRAC_BITS;
  localparam int CW         = COORD_BITS;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_W      = FRAC_BITS + 2;
  localparam int STEP_W     = COORD_BITS + 1;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int ITEM_GOAL  = 1700;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_CAP  = 400000;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          is_last;
  } pixel_t;

  // follows the line state and queues the pixel each accepted item should produce
  class line_pixel_predictor;
    bit [ACC_W-1:0]  acc_x, acc_y;
    bit [INC_W-1:0]  inc_x, inc_y;
    bit [STEP_W-1:0] steps_left;
    bit              active;
    pixel_t          expected_pixels[$];
    int              taken, checked, lines, errors;

    // delta / steps in fixed point, truncated toward zero
    function bit [INC_W-1:0] slope_inc(bit [CW-1:0] from, bit [CW-1:0] to,
                                       bit [STEP_W-1:0] steps);
      bit [CW-1:0]           mag;
      bit [CW+FRAC_BITS:0]   quot;
      mag  = (to >= from) ? to - from : from - to;
      quot = {1'b0, mag, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, steps};
      if (to < from) quot = -quot;
      return quot[INC_W-1:0];
    endfunction

    function bit [CW-1:0] rounded(bit [ACC_W-1:0] acc);
      bit [ACC_W:0] sum;
      sum = {1'b0, acc} + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
      return sum[FRAC_BITS +: CW];
    endfunction

    function void note_item(logic op, logic [CW-1:0] xs, logic [CW-1:0] ys,
                            logic [CW-1:0] xe, logic [CW-1:0] ye);
      bit [CW-1:0]     adx, ady;
      bit [STEP_W-1:0] steps;
      pixel_t          p;
      if (op == dda_pkg::OP_LOAD) begin
        adx   = (xe >= xs) ? xe - xs : xs - xe;
        ady   = (ye >= ys) ? ye - ys : ys - ye;
        steps = {1'b0, (adx > ady) ? adx : ady};
        acc_x = {1'b0, xs, {FRAC_BITS{1'b0}}};
        acc_y = {1'b0, ys, {FRAC_BITS{1'b0}}};
        p.x   = xs;
        p.y   = ys;
        if (steps == 0) begin
          // zero-length line: start point only, no divide
          inc_x      = '0;
          inc_y      = '0;
          steps_left = '0;
          active     = 1'b0;
          p.is_last  = 1'b1;
        end else begin
          inc_x      = slope_inc(xs, xe, steps);
          inc_y      = slope_inc(ys, ye, steps);
          steps_left = steps;
          active     = 1'b1;
          p.is_last  = 1'b0;
        end
        lines++;
      end else begin
        if (!active) return;
        acc_x      = acc_x + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
        acc_y      = acc_y + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
        steps_left = steps_left - STEP_W'(1);
        p.x        = rounded(acc_x);
        p.y        = rounded(acc_y);
        p.is_last  = (steps_left == 0);
        if (p.is_last) active = 1'b0;
      end
      taken++;
      expected_pixels.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel x=%0d y=%0d last=%0b", got.x, got.y, got.is_last);
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.x !== want.x || got.y !== want.y || got.is_last !== want.is_last) begin
        errors++;
        if (errors <= 10)
          $display("pixel %0d mismatch: expected (%0d,%0d,last=%0b) got (%0d,%0d,last=%0b)",
                   checked, want.x, want.y, want.is_last, got.x, got.y, got.is_last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   idle_pct;
  int   stall_pct;
  int   cycle_count;

  line_pixel_predictor pred = new();

  dda_in_if  in_bus ();
  dda_out_if out_bus ();

  dda_line_rasterizer_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               pred.expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial out_bus.ready = 1'b0;

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      pred.check_pixel({out_bus.pixel_x, out_bus.pixel_y, out_bus.last_point});
  end

  task automatic send_item(input logic op, input logic [CW-1:0] xs, input logic [CW-1:0] ys,
                           input logic [CW-1:0] xe, input logic [CW-1:0] ye);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid   = 1'b1;
    in_bus.opcode  = op;
    in_bus.x_start = xs;
    in_bus.y_start = ys;
    in_bus.x_end   = xe;
    in_bus.y_end   = ye;
    do @(posedge clk_i); while (!in_bus.ready);
    pred.note_item(op, xs, ys, xe, ye);
    @(negedge clk_i);
  endtask

  // tick fields carry junk, the block should ignore them
  task automatic send_ticks(input int n);
    repeat (n)
      send_item(dda_pkg::OP_STEP, CW'($urandom_range(COORD_MAX)),
                CW'($urandom_range(COORD_MAX)), CW'($urandom_range(COORD_MAX)),
                CW'($urandom_range(COORD_MAX)));
  endtask

  task automatic drain_pixels();
    in_bus.valid = 1'b0;
    while (pred.expected_pixels.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] pick_end(logic [CW-1:0] start, int span);
    int d;
    d = $urandom_range(span);
    if ($urandom_range(1)) d = -d;
    if (int'(start) + d < 0 || int'(start) + d > COORD_MAX) d = -d;
    return CW'(int'(start) + d);
  endfunction

  // mostly a load followed by its ticks, sometimes cut short or overrun, now and then a lone random item
  task automatic random_line();
    int            r, mode, n, adx, ady, steps;
    logic [CW-1:0] xs, ys, xe, ye;
    r  = $urandom_range(99);
    xs = CW'($urandom_range(COORD_MAX));
    ys = CW'($urandom_range(COORD_MAX));
    if (r < 5) begin
      send_item(1'($urandom_range(1)), xs, ys, CW'($urandom_range(COORD_MAX)),
                CW'($urandom_range(COORD_MAX)));
      return;
    end
    if (r < 9) begin
      xe = xs;
      ye = ys;
    end else if (r < 11) begin
      xe = CW'($urandom_range(COORD_MAX));
      ye = CW'($urandom_range(COORD_MAX));
    end else begin
      xe = pick_end(xs, 20);
      ye = pick_end(ys, 20);
    end
    adx   = (xe >= xs) ? int'(xe - xs) : int'(xs - xe);
    ady   = (ye >= ys) ? int'(ye - ys) : int'(ys - ye);
    steps = (adx > ady) ? adx : ady;
    send_item(dda_pkg::OP_LOAD, xs, ys, xe, ye);
    mode = $urandom_range(99);
    n    = steps;
    if (steps > 40 && mode < 65)
      n = $urandom_range(40);
    else if (mode < 12 && steps > 0)
      n = $urandom_range(steps - 1);
    else if (mode < 25)
      n = steps + $urandom_range(1, 3);
    send_ticks(n);
  endtask

  initial begin
    int phase;
    int goal;
    rst_ni         = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    in_bus.valid   = 1'b0;
    in_bus.opcode  = dda_pkg::OP_STEP;
    in_bus.x_start = '0;
    in_bus.y_start = '0;
    in_bus.x_end   = '0;
    in_bus.y_end   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // tick with no line, then a zero-length line
    send_ticks(1);
    send_item(dda_pkg::OP_LOAD, 7, 9, 7, 9);
    send_ticks(1);
    // full diagonals, each dropped part way by the next load
    send_item(dda_pkg::OP_LOAD, 0, 0, CW'(COORD_MAX), CW'(COORD_MAX));
    send_ticks(2);
    send_item(dda_pkg::OP_LOAD, CW'(COORD_MAX), 0, 0, CW'(COORD_MAX));
    send_ticks(2);
    // negative slopes run to the end, plus one tick past it
    send_item(dda_pkg::OP_LOAD, CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX - 3),
              CW'(COORD_MAX - 1));
    send_ticks(4);
    // horizontal and vertical
    send_item(dda_pkg::OP_LOAD, 0, CW'(COORD_MAX), 3, CW'(COORD_MAX));
    send_ticks(3);
    send_item(dda_pkg::OP_LOAD, 512, 0, 512, 2);
    send_ticks(2);
    // half-way point rounds up
    send_item(dda_pkg::OP_LOAD, 10, 10, 12, 11);
    send_ticks(2);

    for (phase = 0; phase < 4; phase++) begin
      drain_pixels();
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 76;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 76;
        end
        default: begin
          idle_pct  = 11;
          stall_pct = 11;
        end
      endcase
      goal = pred.taken + ITEM_GOAL / 4;
      while (pred.taken < goal) random_line();
    end

    drain_pixels();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d lines, %0d items producing pixels, %0d pixels checked",
             pred.lines, pred.taken, pred.checked);
    $display("flow control: free running, sparse input, heavy output stall, light both");
    if (pred.errors == 0 && pred.expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d pixels never seen", pred.errors,
               pred.expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
